@@ sv/http_chunked_body_decoder_unit_defines.svh @@
// -----------------------------------------------------------------------------
// Assertion macros for the chunked body decoder
// Shared property wrappers; the disabled form is quiet while reset is asserted.
// -----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH

// Check a property only while out of reset
`define HCBD_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("hcbd assertion failed");

// Check a property at every edge, reset included
`define HCBD_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("hcbd assertion failed");

`endif

@@ sv/hcbd_pkg.sv @@
// -----------------------------------------------------------------------------
// hcbd_pkg
// Types, codes, constants and match tables of the chunked body decoder.
// -----------------------------------------------------------------------------
package hcbd_pkg;

	// Defaults for the top-level parameters and the limit register
	localparam int MAX_SIZE_DIGITS_DEF = 16;
	localparam int LENGTH_BITS_DEF     = 32;
	localparam int OUT_DEPTH_DEF       = 4;
	localparam logic [31:0] MAX_BODY_RST = 32'd10485760;

	// Header field match tracking
	localparam int TE_LEN = 18;
	localparam int CK_LEN = 7;
	localparam logic [4:0] MATCH_NONE = 5'd31;
	localparam logic [4:0] MATCH_CK0  = 5'd18;
	localparam logic [4:0] MATCH_CKL  = 5'd24;

	// Characters
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	// Saturated chunk size, 2^63-1
	localparam int SIZE_W = 63;
	localparam logic [SIZE_W-1:0] SIZE_SAT = '1;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_SIZE    = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_TRAILER = 3'd3,
		PH_DONE    = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		SR_NO_HEADER_END = 3'd0,
		SR_NOT_CHUNKED   = 3'd1,
		SR_OVER_LIMIT    = 3'd2,
		SR_ZERO_CHUNK    = 3'd3,
		SR_BAD_SIZE      = 3'd4,
		SR_INPUT_ENDED   = 3'd5
	} stop_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  body_byte;
		logic [31:0] chunk_number;
		logic        chunked_ok;
		logic [31:0] committed_length;
		stop_t       stop_reason;
		logic        final_res;
	} res_t;

	// Up to two results per accepted byte; b is only valid with a
	typedef struct packed {
		logic vld_a;
		logic vld_b;
		res_t res_a;
		res_t res_b;
	} push_t;

	// Lower-case "transfer-encoding:"
	function automatic logic [7:0] te_char(input logic [4:0] idx);
		logic [7:0] c;
		case (idx)
			5'd0:  c = "t";
			5'd1:  c = "r";
			5'd2:  c = "a";
			5'd3:  c = "n";
			5'd4:  c = "s";
			5'd5:  c = "f";
			5'd6:  c = "e";
			5'd7:  c = "r";
			5'd8:  c = "-";
			5'd9:  c = "e";
			5'd10: c = "n";
			5'd11: c = "c";
			5'd12: c = "o";
			5'd13: c = "d";
			5'd14: c = "i";
			5'd15: c = "n";
			5'd16: c = "g";
			5'd17: c = ":";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Lower-case "chunked"
	function automatic logic [7:0] ck_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = "c";
			3'd1: c = "h";
			3'd2: c = "u";
			3'd3: c = "n";
			3'd4: c = "k";
			3'd5: c = "e";
			3'd6: c = "d";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

@@ sv/http_chunked_body_decoder_unit.sv @@
// -----------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// Decodes a chunked HTTP response body from a byte stream.
// -----------------------------------------------------------------------------
// One response byte enters per clock. Each accepted beat is held in an input
// register, where the header scan, size parse or payload count runs, and its
// results go into a small output queue, so a byte passes the input register and
// the queue on its way to the output. The queue takes up to two results a cycle
// and the input side keeps flowing at one beat per cycle as long as the output
// side drains; a payload byte marked last yields a body beat followed by the
// summary beat, and so takes two queue slots. The input stalls only when fewer
// than two queue slots are free. The limit register is written through
// cfg_wr_en/cfg_wr_data; no clearing pass is needed after reset.
`include "http_chunked_body_decoder_unit_defines.svh"

module http_chunked_body_decoder_unit #(
	parameter int MAX_SIZE_DIGITS = hcbd_pkg::MAX_SIZE_DIGITS_DEF,
	parameter int LENGTH_BITS     = hcbd_pkg::LENGTH_BITS_DEF,
	parameter int OUT_DEPTH       = hcbd_pkg::OUT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [7:0] body_byte, [39:8] chunk_number,
	                               // [40] chunked_ok, [72:41] committed_length,
	                               // [75:73] stop_reason, [79:76] zero
	output logic        m_tuser,   // kind
	output logic        m_tlast    // final_res
);
	import hcbd_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       go_s1;
	logic       room2;
	push_t      push;
	res_t       out_res;

	assign go_s1    = vld_s1 && room2;
	assign s_tready = !vld_s1 || go_s1;

	// Input register: load on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	hcbd_core #(
		.MAX_SIZE_DIGITS(MAX_SIZE_DIGITS),
		.LENGTH_BITS    (LENGTH_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.step_en    (go_s1),
		.step_byte  (byte_s1),
		.step_last  (last_s1),
		.push       (push)
	);

	hcbd_out_fifo #(
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room2  (room2),
		.out_vld(m_tvalid),
		.out_rdy(m_tready),
		.out_res(out_res)
	);

	// Pack the result beat
	assign m_tdata = {4'b0000, out_res.stop_reason, out_res.committed_length,
	                  out_res.chunked_ok, out_res.chunk_number, out_res.body_byte};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.final_res;

	`HCBD_ASSERT(a_no_step_when_full, clk, arst_n, go_s1 |-> room2)
	`HCBD_ASSERT(a_hold_stalled, clk, arst_n, (vld_s1 && !go_s1) |=> vld_s1 && $stable(byte_s1))
	`HCBD_ASSERT(a_summary_last, clk, arst_n, (m_tvalid && m_tuser) |-> m_tlast)

endmodule

@@ sv/hcbd_out_fifo.sv @@
// -----------------------------------------------------------------------------
// hcbd_out_fifo
// Result queue: takes up to two results a cycle, hands out one beat a cycle while out_rdy is high.
// -----------------------------------------------------------------------------
`include "http_chunked_body_decoder_unit_defines.svh"

module hcbd_out_fifo #(
	parameter int DEPTH = hcbd_pkg::OUT_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  hcbd_pkg::push_t push,
	output logic           room2,
	output logic           out_vld,
	input  logic           out_rdy,
	output hcbd_pkg::res_t out_res
);
	import hcbd_pkg::*;

	localparam int PW = $clog2(DEPTH);

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   cnt_q;
	logic [PW-1:0] wr_ptr_b;
	logic [PW:0]   n_push;
	logic          pop;

	assign out_vld  = (cnt_q != '0);
	assign out_res  = mem_q[rd_ptr_q];
	assign pop      = out_vld && out_rdy;
	assign room2    = (cnt_q <= (PW+1)'(DEPTH - 2));
	assign wr_ptr_b = wr_ptr_q + PW'(1);
	assign n_push   = (PW+1)'(push.vld_a) + (PW+1)'(push.vld_b);

	// Store entries
	always_ff @(posedge clk) begin
		if (push.vld_a) begin
			mem_q[wr_ptr_q] <= push.res_a;
		end
		if (push.vld_b) begin
			mem_q[wr_ptr_b] <= push.res_b;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[PW-1:0];
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			cnt_q    <= cnt_q + n_push - (PW+1)'(pop);
		end
	end

	`HCBD_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= (PW+1)'(DEPTH))
	`HCBD_ASSERT(a_pair_order, clk, arst_n, push.vld_b |-> push.vld_a)
	`HCBD_ASSERT(a_pop_dec, clk, arst_n, (pop && !push.vld_a) |=> cnt_q == $past(cnt_q) - 1'b1)

endmodule

@@ sv/hcbd_core.sv @@
// -----------------------------------------------------------------------------
// hcbd_core
// Per-byte header scan, chunk size parse, payload tracking and summary build.
// -----------------------------------------------------------------------------
`include "http_chunked_body_decoder_unit_defines.svh"

module hcbd_core #(
	parameter int MAX_SIZE_DIGITS = hcbd_pkg::MAX_SIZE_DIGITS_DEF,
	parameter int LENGTH_BITS     = hcbd_pkg::LENGTH_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [31:0]     cfg_wr_data,
	input  logic            step_en,
	input  logic [7:0]      step_byte,
	input  logic            step_last,
	output hcbd_pkg::push_t push
);
	import hcbd_pkg::*;

	localparam int CNT_W = $clog2(MAX_SIZE_DIGITS + 1);
	localparam int SUM_W = 65;

	// State registers
	logic [31:0]            max_q;
	phase_t                 phase_q, n_phase;
	logic [1:0]             hep_q, n_hep;
	logic [4:0]             fmi_q, n_fmi;
	logic                   chunked_q, n_chunked;
	logic [SIZE_W-1:0]      size_q, n_size;
	logic [CNT_W-1:0]       cnt_q, n_cnt;
	logic                   bad_q, n_bad;
	logic [SIZE_W-1:0]      rem_q, n_rem;
	logic                   trail_q, n_trail;
	logic [31:0]            chunk_q, n_chunk;
	logic [LENGTH_BITS-1:0] committed_q, n_committed;
	stop_t                  stop_q, n_stop;

	// Byte decode
	logic [7:0]       lb;
	logic [2:0]       hnext;
	logic [2:0]       ck_idx;
	logic             is_hex;
	logic [3:0]       digit;
	logic             size_active;
	logic [SUM_W-1:0] lim_x, com_x, sum_x;
	logic             fits;
	logic             body;
	stop_t            why;
	logic             ok;
	logic [63:0]      com64;
	res_t             body_res, sum_res;

	assign lb     = (step_byte >= "A" && step_byte <= "Z") ? step_byte + 8'd32 : step_byte;
	assign ck_idx = 3'(fmi_q - MATCH_CK0);
	assign size_active = !bad_q && (cnt_q < CNT_W'(MAX_SIZE_DIGITS));

	// Hex digit value
	always_comb begin
		is_hex = 1'b1;
		digit  = 4'd0;
		if (step_byte >= "0" && step_byte <= "9") begin
			digit = 4'(step_byte - "0");
		end else if (step_byte >= "a" && step_byte <= "f") begin
			digit = 4'(step_byte - "a" + 8'd10);
		end else if (step_byte >= "A" && step_byte <= "F") begin
			digit = 4'(step_byte - "A" + 8'd10);
		end else begin
			is_hex = 1'b0;
		end
	end

	// Limit check at chunk end: committed + size + 1 <= limit
	assign lim_x = SUM_W'(max_q);
	assign com_x = SUM_W'(committed_q);
	assign sum_x = com_x + SUM_W'(size_q);
	assign fits  = (lim_x > com_x) && (sum_x < lim_x);

	// Header end progress
	always_comb begin
		if (step_byte == CH_CR) begin
			hnext = (hep_q == 2'd2) ? 3'd3 : 3'd1;
		end else if (step_byte == CH_LF && (hep_q == 2'd1 || hep_q == 2'd3)) begin
			hnext = 3'({1'b0, hep_q} + 3'd1);
		end else begin
			hnext = 3'd0;
		end
	end

	// Next state for one byte
	always_comb begin
		n_phase     = phase_q;
		n_hep       = hep_q;
		n_fmi       = fmi_q;
		n_chunked   = chunked_q;
		n_size      = size_q;
		n_cnt       = cnt_q;
		n_bad       = bad_q;
		n_rem       = rem_q;
		n_trail     = trail_q;
		n_chunk     = chunk_q;
		n_committed = committed_q;
		n_stop      = stop_q;
		body        = 1'b0;

		case (phase_q)
			PH_HEADER: begin
				// match the transfer coding field
				if (fmi_q < 5'(TE_LEN)) begin
					n_fmi = (lb == te_char(fmi_q)) ? fmi_q + 5'd1 : MATCH_NONE;
				end else if (fmi_q <= MATCH_CKL) begin
					if (fmi_q == MATCH_CK0 && (step_byte == CH_SP || step_byte == CH_TAB)) begin
						n_fmi = fmi_q;
					end else if (lb == ck_char(ck_idx)) begin
						if (fmi_q == MATCH_CKL) begin
							n_chunked = 1'b1;
							n_fmi     = MATCH_NONE;
						end else begin
							n_fmi = fmi_q + 5'd1;
						end
					end else begin
						n_fmi = MATCH_NONE;
					end
				end
				if (hnext == 3'd2 || hnext == 3'd4) begin
					n_fmi = '0;
				end
				n_hep = (hnext == 3'd4) ? 2'd0 : hnext[1:0];
				// blank line closes the headers
				if (hnext == 3'd4) begin
					if (n_chunked) begin
						n_phase = PH_SIZE;
						n_size  = '0;
						n_cnt   = '0;
						n_bad   = 1'b0;
					end else begin
						n_phase = PH_DONE;
						n_stop  = SR_NOT_CHUNKED;
					end
				end
			end
			PH_SIZE: begin
				if (hep_q != 2'd0 && step_byte == CH_LF) begin
					// size line complete
					n_hep = 2'd0;
					if (cnt_q == '0 || bad_q) begin
						n_phase = PH_DONE;
						n_stop  = SR_BAD_SIZE;
					end else if (size_q == '0) begin
						n_phase = PH_DONE;
						n_stop  = SR_ZERO_CHUNK;
					end else begin
						n_phase = PH_PAYLOAD;
						n_rem   = size_q;
					end
				end else if (hep_q != 2'd0) begin
					// a lone CR counts as a bad character
					if (size_active) begin
						n_bad = 1'b1;
					end
					n_hep = (step_byte == CH_CR) ? 2'd1 : 2'd0;
				end else if (step_byte == CH_CR) begin
					n_hep = 2'd1;
				end else if (size_active) begin
					if (is_hex) begin
						n_size = (|size_q[SIZE_W-1:SIZE_W-4]) ? SIZE_SAT
						                                      : {size_q[SIZE_W-5:0], digit};
						n_cnt  = cnt_q + CNT_W'(1);
					end else begin
						n_bad = 1'b1;
					end
				end
			end
			PH_PAYLOAD: begin
				body  = 1'b1;
				n_rem = rem_q - SIZE_W'(1);
				if (rem_q == SIZE_W'(1)) begin
					n_phase = PH_TRAILER;
					n_trail = 1'b0;
				end
			end
			PH_TRAILER: begin
				if (!trail_q) begin
					n_trail = 1'b1;
				end else if (!fits) begin
					n_committed = '0;
					n_phase     = PH_DONE;
					n_stop      = SR_OVER_LIMIT;
				end else begin
					n_committed = sum_x[LENGTH_BITS-1:0];
					n_chunk     = chunk_q + 32'd1;
					n_phase     = PH_SIZE;
					n_size      = '0;
					n_cnt       = '0;
					n_bad       = 1'b0;
					n_hep       = 2'd0;
				end
			end
			default: begin
			end
		endcase
	end

	// Summary fields from the state after this byte
	always_comb begin
		if (n_phase == PH_HEADER) begin
			why = SR_NO_HEADER_END;
		end else if (n_phase == PH_DONE) begin
			why = n_stop;
		end else begin
			why = SR_INPUT_ENDED;
		end
	end

	assign ok    = (why == SR_ZERO_CHUNK) || (why == SR_BAD_SIZE) || (why == SR_INPUT_ENDED);
	assign com64 = 64'(n_committed);

	always_comb begin
		body_res                  = '0;
		body_res.body_byte        = step_byte;
		body_res.chunk_number     = chunk_q;
		body_res.stop_reason      = SR_NO_HEADER_END;
		sum_res                   = '0;
		sum_res.kind              = 1'b1;
		sum_res.chunked_ok        = ok;
		sum_res.committed_length  = ok ? com64[31:0] : 32'd0;
		sum_res.stop_reason       = why;
		sum_res.final_res         = 1'b1;
	end

	// Results: body beat first, summary after it
	always_comb begin
		push.vld_a = step_en && (body || step_last);
		push.vld_b = step_en && body && step_last;
		push.res_a = body ? body_res : sum_res;
		push.res_b = sum_res;
	end

	// Limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_BODY_RST;
		end else if (cfg_wr_en) begin
			max_q <= cfg_wr_data;
		end
	end

	// Response state; clear on the closing byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hep_q       <= '0;
			fmi_q       <= '0;
			chunked_q   <= 1'b0;
			size_q      <= '0;
			cnt_q       <= '0;
			bad_q       <= 1'b0;
			rem_q       <= '0;
			trail_q     <= 1'b0;
			chunk_q     <= '0;
			committed_q <= '0;
			stop_q      <= SR_NO_HEADER_END;
		end else if (step_en) begin
			if (step_last) begin
				phase_q     <= PH_HEADER;
				hep_q       <= '0;
				fmi_q       <= '0;
				chunked_q   <= 1'b0;
				size_q      <= '0;
				cnt_q       <= '0;
				bad_q       <= 1'b0;
				rem_q       <= '0;
				trail_q     <= 1'b0;
				chunk_q     <= '0;
				committed_q <= '0;
				stop_q      <= SR_NO_HEADER_END;
			end else begin
				phase_q     <= n_phase;
				hep_q       <= n_hep;
				fmi_q       <= n_fmi;
				chunked_q   <= n_chunked;
				size_q      <= n_size;
				cnt_q       <= n_cnt;
				bad_q       <= n_bad;
				rem_q       <= n_rem;
				trail_q     <= n_trail;
				chunk_q     <= n_chunk;
				committed_q <= n_committed;
				stop_q      <= n_stop;
			end
		end
	end

	`HCBD_ASSERT_ALWAYS(a_payload_rem, clk, (phase_q == PH_PAYLOAD) |-> (rem_q != '0))
	`HCBD_ASSERT(a_cnt_max, clk, arst_n, cnt_q <= CNT_W'(MAX_SIZE_DIGITS))
	`HCBD_ASSERT(a_chunk_step, clk, arst_n, !$stable(chunk_q) |-> ($past(phase_q) == PH_TRAILER) || $past(step_last))

endmodule
